// ===== hdl/wmalu_pkg.sv =====
`default_nettype none
package wmalu_pkg;
	typedef enum logic [3:0] {
		FN_ADD = 4'd0, FN_SUB = 4'd1, FN_MUL = 4'd2, FN_DIV = 4'd3, FN_MOD = 4'd4,
		FN_SHL = 4'd5, FN_SHR = 4'd6, FN_AND = 4'd7, FN_XOR = 4'd8, FN_OR = 4'd9,
		FN_NOT = 4'd10, FN_NEG = 4'd11, FN_CMP = 4'd12, FN_R13 = 4'd13,
		FN_R14 = 4'd14, FN_R15 = 4'd15
	} func_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [1:0] ST_DIVZERO   = 2'd3;

	localparam logic [1:0] CMP_EQ = 2'd0;
	localparam logic [1:0] CMP_GT = 2'd1;
	localparam logic [1:0] CMP_LT = 2'd2;
endpackage
`default_nettype wire

// ===== hdl/wmalu_req_if.sv =====
`default_nettype none
interface wmalu_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  func;
	logic [63:0] left_value;
	logic [63:0] right_value;
	logic [6:0]  width;
	modport source (output valid, func, left_value, right_value, width, input ready);
	modport sink (input valid, func, left_value, right_value, width, output ready);
endinterface
`default_nettype wire

// ===== hdl/wmalu_rsp_if.sv =====
`default_nettype none
interface wmalu_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_value;
	logic [1:0]  status;
	logic [1:0]  compare;
	modport source (output valid, result_value, status, compare, input ready);
	modport sink (input valid, result_value, status, compare, output ready);
endinterface
`default_nettype wire

// ===== hdl/width_masked_integer_alu_unit.sv =====
// Pipeline: masking stage, 64 restoring divide stages, three pass-through stages,
// then the output register fed by the final select on the last stage.
// Throughput: one operation per cycle unless the output stalls; the divider is fully
// pipelined, one quotient bit per stage, and a global stall freezes every stage at once.
// Reset: arst_n clears all valid bits asynchronously; payload registers are not reset.
`default_nettype none
module width_masked_integer_alu_unit import wmalu_pkg::*; #(
	parameter int DATA_WIDTH = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	wmalu_req_if.sink in_ch,
	wmalu_rsp_if.source out_ch
);
	localparam int NDIV = DATA_WIDTH;
	localparam int DEPTH = NDIV + 3;
	localparam int WB = $clog2(DATA_WIDTH + 1);
	localparam int HW = DATA_WIDTH / 2;
	localparam int LW = DATA_WIDTH - HW;
	localparam int PW = 2 * DATA_WIDTH;

	typedef logic [DATA_WIDTH-1:0] d_t;

	// One stall for the whole pipe: advance whenever the output register can move.
	logic adv;
	logic out_v_q;
	assign adv = !out_v_q || out_ch.ready;
	assign in_ch.ready = adv;

	// Stage 1: width saturation and operand masking.
	logic        v_s1;
	func_t       fn_s1;
	d_t          x_s1, y_s1, m_s1;
	logic [WB-1:0] w_s1;
	logic [6:0]  win;
	logic [WB-1:0] wsat;
	d_t          msk;
	always_comb begin
		win = in_ch.width;
		if (win == 7'd0) wsat = WB'(1);
		else if (32'(win) > DATA_WIDTH) wsat = WB'(DATA_WIDTH);
		else wsat = WB'(win);
		msk = (32'(wsat) >= DATA_WIDTH) ? '1 : ((d_t'(1) << wsat) - d_t'(1));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_ch.valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			fn_s1 <= func_t'(in_ch.func);
			x_s1 <= d_t'(in_ch.left_value) & msk;
			y_s1 <= d_t'(in_ch.right_value) & msk;
			m_s1 <= msk;
			w_s1 <= wsat;
		end
	end

	// Pipeline payload arrays indexed by stage (k = 0 is the first divide stage).
	logic          v_p   [DEPTH];
	func_t         fn_p  [DEPTH];
	d_t            x_p   [DEPTH];
	d_t            y_p   [DEPTH];
	d_t            m_p   [DEPTH];
	logic [WB-1:0] w_p   [DEPTH];
	d_t            rem_p [DEPTH];
	d_t            quo_p [DEPTH];

	// Stages k < NDIV divide: restoring, one quotient bit each, most significant first.
	for (genvar k = 0; k < DEPTH; k++) begin : g_stage
		logic          vi;
		func_t         fi;
		d_t            xi, yi, mi, ri, qi;
		logic [WB-1:0] wi;
		d_t            rn, qn;
		logic [DATA_WIDTH:0] trial;
		if (k == 0) begin : g_first
			assign vi = v_s1; assign fi = fn_s1; assign xi = x_s1;
			assign yi = y_s1; assign mi = m_s1; assign wi = w_s1;
			assign ri = '0; assign qi = '0;
		end else begin : g_next
			assign vi = v_p[k-1]; assign fi = fn_p[k-1]; assign xi = x_p[k-1];
			assign yi = y_p[k-1]; assign mi = m_p[k-1]; assign wi = w_p[k-1];
			assign ri = rem_p[k-1]; assign qi = quo_p[k-1];
		end
		always_comb begin
			rn = ri; qn = qi; trial = '0;
			if (k < NDIV) begin
				trial = {ri, xi[NDIV-1-k]};
				if (trial >= {1'b0, yi}) begin
					rn = d_t'(trial - {1'b0, yi});
					qn = qi | (d_t'(1) << (NDIV-1-k));
				end else begin
					rn = d_t'(trial);
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_p[k] <= 1'b0;
			else if (adv) v_p[k] <= vi;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				fn_p[k] <= fi; x_p[k] <= xi; y_p[k] <= yi; m_p[k] <= mi;
				w_p[k] <= wi; rem_p[k] <= rn; quo_p[k] <= qn;
			end
		end
	end

	// Multiplier: four partial products in the first divide stage, summed in the
	// stage after it; the result rides along to the end.
	logic [PW-1:0] pll_q, plh_q, phl_q, phh_q, prod_q, prod_s;
	logic [PW-1:0] prod_p [2:DEPTH-1];
	always_ff @(posedge clk) begin
		if (adv) begin
			pll_q <= PW'(x_s1[LW-1:0] * y_s1[LW-1:0]);
			plh_q <= PW'(x_s1[LW-1:0] * y_s1[DATA_WIDTH-1:LW]) << LW;
			phl_q <= PW'(x_s1[DATA_WIDTH-1:LW] * y_s1[LW-1:0]) << LW;
			phh_q <= PW'(x_s1[DATA_WIDTH-1:LW] * y_s1[DATA_WIDTH-1:LW]) << (2*LW);
			prod_q <= (pll_q + plh_q) + (phl_q + phh_q);
		end
	end
	// prod_q lines up with stage 1; carry it down the pipe from stage 2 on.
	for (genvar k = 2; k < DEPTH; k++) begin : g_prod
		if (k == 2) begin : g_head
			always_ff @(posedge clk) begin
				if (adv) prod_p[k] <= prod_q;
			end
		end else begin : g_tail
			always_ff @(posedge clk) begin
				if (adv) prod_p[k] <= prod_p[k-1];
			end
		end
	end
	assign prod_s = prod_p[DEPTH-1];

	// Final select on the last stage.
	func_t         fl;
	d_t            xl, yl, ml, r;
	logic [WB-1:0] wl;
	logic [1:0]    st, cm;
	logic [DATA_WIDTH:0] sum;
	d_t            sh;
	logic          big;
	always_comb begin
		fl = fn_p[DEPTH-1]; xl = x_p[DEPTH-1]; yl = y_p[DEPTH-1];
		ml = m_p[DEPTH-1]; wl = w_p[DEPTH-1];
		sum = {1'b0, xl} + {1'b0, yl};
		big = yl >= d_t'(wl);
		r = xl; st = ST_OK; sh = '0;
		unique case (fl)
			FN_ADD: begin
				r = d_t'(sum) & ml;
				if (sum[DATA_WIDTH] || ((d_t'(sum) & ~ml) != '0)) st = ST_OVERFLOW;
			end
			FN_SUB: begin
				r = (xl - yl) & ml;
				if (yl > xl) st = ST_UNDERFLOW;
			end
			FN_MUL: begin
				r = d_t'(prod_s) & ml;
				if ((prod_s[PW-1:DATA_WIDTH] != '0) || ((d_t'(prod_s) & ~ml) != '0))
					st = ST_OVERFLOW;
			end
			FN_DIV: begin
				if (yl == '0) st = ST_DIVZERO; else r = quo_p[DEPTH-1];
			end
			FN_MOD: begin
				if (yl == '0) st = ST_DIVZERO; else r = rem_p[DEPTH-1];
			end
			FN_SHL: begin
				if (big) begin
					r = '0; if (xl != '0) st = ST_OVERFLOW;
				end else begin
					sh = (xl << yl) & ml;
					r = sh;
					if ((sh >> yl) != xl) st = ST_OVERFLOW;
				end
			end
			FN_SHR: begin
				if (big) begin
					r = '0; if (xl != '0) st = ST_UNDERFLOW;
				end else begin
					sh = xl >> yl;
					r = sh;
					if ((sh << yl) != xl) st = ST_UNDERFLOW;
				end
			end
			FN_AND: r = xl & yl;
			FN_XOR: r = xl ^ yl;
			FN_OR:  r = xl | yl;
			FN_NOT: r = ~xl & ml;
			FN_NEG: r = (d_t'(0) - xl) & ml;
			default: r = xl;
		endcase
		if (xl == yl) cm = CMP_EQ;
		else if (xl > yl) cm = CMP_GT;
		else cm = CMP_LT;
	end

	logic [63:0] res_q;
	logic [1:0]  st_q, cm_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (adv) out_v_q <= v_p[DEPTH-1];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= 64'(r);
			st_q <= st;
			cm_q <= cm;
		end
	end
	assign out_ch.valid = out_v_q;
	assign out_ch.result_value = res_q;
	assign out_ch.status = st_q;
	assign out_ch.compare = cm_q;

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_ch.ready |=> out_v_q && $stable(res_q) && $stable(st_q))
		else $error("result changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready == (!out_v_q || out_ch.ready))
		else $error("ready does not follow output stall");
	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> cm_q != 2'd3)
		else $error("bad compare code");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s1 |=> v_p[0])
		else $error("item lost entering divider");
`endif
endmodule
`default_nettype wire

// ===== tb/width_masked_integer_alu_unit_tb.sv =====
`timescale 1ns / 1ps
module width_masked_integer_alu_unit_tb;
	import wmalu_pkg::*;

	typedef struct packed {
		logic [63:0] result_value;
		logic [1:0]  status;
		logic [1:0]  compare;
	} alu_answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	wmalu_req_if req_ch();
	wmalu_rsp_if rsp_ch();

	width_masked_integer_alu_unit #(.DATA_WIDTH(64)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(req_ch.sink),
		.out_ch(rsp_ch.source)
	);

	always #6 clk = ~clk;

	alu_answer_t answers_due[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	bit stall_free = 1'b0;

	initial begin
		req_ch.valid = 1'b0;
		req_ch.func = '0;
		req_ch.left_value = '0;
		req_ch.right_value = '0;
		req_ch.width = 7'd1;
		rsp_ch.ready = 1'b0;
	end

	// Works out the answer the unit should give for one operation.
	function automatic alu_answer_t compute_answer(func_t fn, logic [63:0] lhs,
			logic [63:0] rhs, logic [6:0] width_in);
		alu_answer_t a;
		int unsigned w;
		logic [63:0] m, x, y, r;
		logic [127:0] prod;
		w = {25'd0, width_in};
		if (w == 0) w = 1;
		if (w > 64) w = 64;
		m = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
		x = lhs & m;
		y = rhs & m;
		r = x;
		a.status = ST_OK;
		case (fn)
			FN_ADD: begin
				r = (x + y) & m;
				if (y > m - x) a.status = ST_OVERFLOW;
			end
			FN_SUB: begin
				r = (x - y) & m;
				if (y > x) a.status = ST_UNDERFLOW;
			end
			FN_MUL: begin
				prod = x * y;
				r = prod[63:0] & m;
				if (prod > {64'd0, m}) a.status = ST_OVERFLOW;
			end
			FN_DIV: begin
				if (y == 0) a.status = ST_DIVZERO;
				else r = x / y;
			end
			FN_MOD: begin
				if (y == 0) a.status = ST_DIVZERO;
				else r = x % y;
			end
			FN_SHL: begin
				if (y >= w) begin
					r = '0;
					if (x != 0) a.status = ST_OVERFLOW;
				end else begin
					r = (x << y) & m;
					if ((r >> y) != x) a.status = ST_OVERFLOW;
				end
			end
			FN_SHR: begin
				if (y >= w) begin
					r = '0;
					if (x != 0) a.status = ST_UNDERFLOW;
				end else begin
					r = x >> y;
					if ((r << y) != x) a.status = ST_UNDERFLOW;
				end
			end
			FN_AND: r = x & y;
			FN_XOR: r = x ^ y;
			FN_OR: r = x | y;
			FN_NOT: r = ~x & m;
			FN_NEG: r = (64'd0 - x) & m;
			default: r = x;
		endcase
		a.result_value = r;
		a.compare = (x == y) ? CMP_EQ : ((x > y) ? CMP_GT : CMP_LT);
		return a;
	endfunction

	task automatic issue_op(func_t fn, logic [63:0] lhs, logic [63:0] rhs,
			logic [6:0] width_in);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (req_ch.valid) begin
				req_ch.valid <= 1'b0;
				if (gap == 0) gap = 1;
			end
			repeat (gap) @(negedge clk);
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.func <= fn;
		req_ch.left_value <= lhs;
		req_ch.right_value <= rhs;
		req_ch.width <= width_in;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		answers_due.push_back(compute_answer(fn, lhs, rhs, width_in));
		@(negedge clk);
	endtask

	task automatic end_stream();
		req_ch.valid <= 1'b0;
		burst_left = 0;
	endtask

	// Receiver stall pattern: free-running stretches alternate with random stalls.
	always @(negedge clk) begin
		if ($urandom_range(0, 63) == 0) stall_free = ~stall_free;
		rsp_ch.ready <= stall_free ? 1'b1 : ($urandom_range(0, 2) != 0);
	end

	always @(posedge clk) begin
		alu_answer_t exp_a;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (answers_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", rsp_ch.result_value);
			end else begin
				exp_a = answers_due.pop_front();
				if (rsp_ch.result_value !== exp_a.result_value ||
						rsp_ch.status !== exp_a.status ||
						rsp_ch.compare !== exp_a.compare) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
							exp_a.result_value, exp_a.status, exp_a.compare,
							rsp_ch.result_value, rsp_ch.status, rsp_ch.compare);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 5000) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic test_arith_edges();
		issue_op(FN_ADD, '1, 64'd1, 7'd64);
		issue_op(FN_ADD, 64'hFF, 64'h01, 7'd8);
		issue_op(FN_SUB, 64'd0, 64'd1, 7'd1);
		issue_op(FN_SUB, 64'd5, 64'd3, 7'd0);
		issue_op(FN_MUL, '1, '1, 7'd64);
		issue_op(FN_MUL, 64'h10, 64'h10, 7'd8);
		issue_op(FN_NEG, 64'd1, 64'd0, 7'd127);
		issue_op(FN_NOT, '0, '1, 7'd100);
	endtask

	task automatic test_divide_by_zero();
		issue_op(FN_DIV, 64'h1234, 64'h100, 7'd8);
		issue_op(FN_MOD, '1, 64'd0, 7'd64);
		issue_op(FN_DIV, '1, 64'd7, 7'd64);
		issue_op(FN_MOD, '1, 64'd7, 7'd64);
	endtask

	task automatic test_shifts();
		issue_op(FN_SHL, 64'h81, 64'd1, 7'd8);
		issue_op(FN_SHL, 64'd1, 64'd64, 7'd64);
		issue_op(FN_SHR, 64'd3, 64'd1, 7'd4);
		issue_op(FN_SHR, '1, 64'd63, 7'd64);
		issue_op(FN_SHR, 64'd0, 64'd200, 7'd64);
	endtask

	task automatic test_logic_and_compare();
		issue_op(FN_AND, '1, 64'hA5A5, 7'd64);
		issue_op(FN_XOR, '1, '0, 7'd33);
		issue_op(FN_OR, 64'h5, 64'hA, 7'd4);
		issue_op(FN_CMP, 64'd7, 64'd7, 7'd3);
		issue_op(FN_CMP, 64'd2, 64'd9, 7'd64);
		issue_op(FN_R13, 64'hABC, 64'd1, 7'd12);
		issue_op(FN_R15, '1, '1, 7'd64);
	endtask

	task automatic test_random_ops();
		logic [63:0] lhs, rhs;
		logic [6:0] w;
		func_t fn;
		for (int i = 0; i < 450; i++) begin
			fn = func_t'($urandom_range(0, 15));
			case ($urandom_range(0, 5))
				0: w = 7'd64;
				1: w = 7'($urandom_range(0, 127));
				default: w = 7'($urandom_range(1, 64));
			endcase
			lhs = rand64();
			rhs = rand64();
			// Small shift counts exercise the in-range shift paths; some divisors are forced to zero.
			if ((fn == FN_SHL || fn == FN_SHR) && $urandom_range(0, 2) != 0)
				rhs = 64'($urandom_range(0, 70));
			if ((fn == FN_DIV || fn == FN_MOD) && $urandom_range(0, 7) == 0)
				rhs = '0;
			if ($urandom_range(0, 9) == 0) rhs = lhs;
			issue_op(fn, lhs, rhs, w);
		end
		end_stream();
	endtask

	initial begin
		int waited;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_arith_edges();
		test_divide_by_zero();
		test_shifts();
		test_logic_and_compare();
		test_random_ops();
		waited = 0;
		while (answers_due.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (100) @(posedge clk);
		if (mismatches == 0 && answers_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
